### hdl/assert_macros.svh
// Assertion macros shared by the line point stepper RTL.
// No dependencies; expects clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define LPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/lps_pkg.sv
// Shared types and constants for the line point stepper.
// No dependencies.
package lps_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned RES_DEPTH      = 4;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned APB_DATA_W     = 32;

  localparam logic [APB_ADDR_W-1:0] REG_CONNECTED_MODE = 3'd0;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

  // flags carried with each result point
  typedef struct packed {
    logic line_done;
    logic last_of_step;
  } res_flags_t;

endpackage

### hdl/line_point_stepper_core.sv
// Line point stepper top level: stream ports, APB register, line state.
// Depends on lps_pkg, lps_setup, lps_step, lps_result_fifo, assert_macros.svh.
//
// Bresenham line rasterizer. A start item (tuser = 0) loads the two endpoints
// in tdata and gives no point; it replaces any line still in progress. Each
// step item (tuser = 1) gives the point of the current major-axis column in
// original axes, and in connected mode (register 0, bit 0) also the point
// after a minor-axis step when that point lies within the line. A step when
// no line is loaded, or after the last column, gives nothing. The endpoint
// setup into the line state registers and the column step into the
// 4-entry result queue are combinational adds and compares. Items flow
// at one per cycle while each step gives one point and the point output
// keeps up; a step that gives two points uses the single result port
// twice, and s_axis_tready drops while fewer than two queue slots are
// free. A step's points are written into the result queue when taken.
`include "assert_macros.svh"
module line_point_stepper_core import lps_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // item input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // x_start, y_start, x_end, y_end from bit 0 up, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic                   s_axis_tuser,
  // point output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // point_x, point_y from bit 0 up, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // last_of_step
  output logic                   m_axis_tlast,
  // line_done
  output logic                   m_axis_tuser,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned RES_W = 2 * CW + 2;

  // configuration
  logic connected_q;

  // line state
  logic signed [CW-1:0] major_pos_q, major_pos_d, major_end_q, major_end_d;
  logic signed [CW:0]   minor_pos_q, minor_pos_d;
  logic signed [CW-1:0] minor_end_q, minor_end_d;
  logic signed [CW+2:0] error_q, error_d;
  logic [CW:0]          major_span_q, major_span_d, minor_span_q, minor_span_d;
  logic                 dir_down_q, dir_down_d, swapped_q, swapped_d;
  logic                 active_q, active_d;

  // setup outputs
  logic                 su_swapped, su_dir_down;
  logic signed [CW-1:0] su_maj_start, su_maj_end, su_min_start, su_min_end;
  logic [CW:0]          su_maj_span, su_min_span;

  // step outputs
  logic signed [CW-1:0] st_major_pos;
  logic signed [CW:0]   st_minor_pos;
  logic signed [CW+2:0] st_error;
  logic                 st_done, st_extra;
  logic signed [CW-1:0] p0_x, p0_y, p1_x, p1_y;

  // queue interface
  logic                 in_acc, is_start, is_step;
  logic                 push0, push1, q_room;
  res_flags_t           f0, f1, fo;
  logic [RES_W-1:0]     res0, res1, res_out;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_start = kind_e'(s_axis_tuser) == KIND_START;
  assign is_step  = kind_e'(s_axis_tuser) == KIND_STEP;
  assign s_axis_tready = q_room;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_CONNECTED_MODE) ? APB_DATA_W'(connected_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connected_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == REG_CONNECTED_MODE) begin
      connected_q <= pwdata[0];
    end
  end

  lps_setup #(.COORD_BITS(CW)) u_setup (
    .x_start_i     (s_axis_tdata[CW-1:0]),
    .y_start_i     (s_axis_tdata[2*CW-1:CW]),
    .x_end_i       (s_axis_tdata[3*CW-1:2*CW]),
    .y_end_i       (s_axis_tdata[4*CW-1:3*CW]),
    .swapped_o     (su_swapped),
    .major_start_o (su_maj_start),
    .major_end_o   (su_maj_end),
    .minor_start_o (su_min_start),
    .minor_end_o   (su_min_end),
    .major_span_o  (su_maj_span),
    .minor_span_o  (su_min_span),
    .dir_down_o    (su_dir_down)
  );

  lps_step #(.COORD_BITS(CW)) u_step (
    .major_pos_i  (major_pos_q),
    .major_end_i  (major_end_q),
    .minor_pos_i  (minor_pos_q),
    .minor_end_i  (minor_end_q),
    .error_i      (error_q),
    .major_span_i (major_span_q),
    .minor_span_i (minor_span_q),
    .dir_down_i   (dir_down_q),
    .swapped_i    (swapped_q),
    .connected_i  (connected_q),
    .major_pos_o  (st_major_pos),
    .minor_pos_o  (st_minor_pos),
    .error_o      (st_error),
    .done_o       (st_done),
    .extra_o      (st_extra),
    .p0_x_o       (p0_x),
    .p0_y_o       (p0_y),
    .p1_x_o       (p1_x),
    .p1_y_o       (p1_y)
  );

  // state update
  always_comb begin
    major_pos_d  = major_pos_q;
    major_end_d  = major_end_q;
    minor_pos_d  = minor_pos_q;
    minor_end_d  = minor_end_q;
    error_d      = error_q;
    major_span_d = major_span_q;
    minor_span_d = minor_span_q;
    dir_down_d   = dir_down_q;
    swapped_d    = swapped_q;
    active_d     = active_q;
    if (in_acc && is_start) begin
      major_pos_d  = su_maj_start;
      major_end_d  = su_maj_end;
      minor_pos_d  = $signed({su_min_start[CW-1], su_min_start});
      minor_end_d  = su_min_end;
      error_d      = '0;
      major_span_d = su_maj_span;
      minor_span_d = su_min_span;
      dir_down_d   = su_dir_down;
      swapped_d    = su_swapped;
      active_d     = 1'b1;
    end else if (in_acc && is_step && active_q) begin
      major_pos_d = st_major_pos;
      minor_pos_d = st_minor_pos;
      error_d     = st_error;
      active_d    = !st_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_pos_q  <= '0;
      major_end_q  <= '0;
      minor_pos_q  <= '0;
      minor_end_q  <= '0;
      error_q      <= '0;
      major_span_q <= '0;
      minor_span_q <= '0;
      dir_down_q   <= 1'b0;
      swapped_q    <= 1'b0;
      active_q     <= 1'b0;
    end else begin
      major_pos_q  <= major_pos_d;
      major_end_q  <= major_end_d;
      minor_pos_q  <= minor_pos_d;
      minor_end_q  <= minor_end_d;
      error_q      <= error_d;
      major_span_q <= major_span_d;
      minor_span_q <= minor_span_d;
      dir_down_q   <= dir_down_d;
      swapped_q    <= swapped_d;
      active_q     <= active_d;
    end
  end

  // result points: first has last set unless the extra point follows
  always_comb begin
    push0 = in_acc && is_step && active_q;
    push1 = push0 && st_extra;
    f0.line_done    = st_done;
    f0.last_of_step = !st_extra;
    f1.line_done    = st_done;
    f1.last_of_step = 1'b1;
    res0 = {f0, p0_y, p0_x};
    res1 = {f1, p1_y, p1_x};
  end

  lps_result_fifo #(.WIDTH(RES_W)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .data0_i (res0),
    .data1_i (res1),
    .room_o  (q_room),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .data_o  (res_out)
  );

  assign fo           = res_out[RES_W-1:2*CW];
  assign m_axis_tdata = OUT_TDATA_W'(res_out[2*CW-1:0]);
  assign m_axis_tlast = fo.last_of_step;
  assign m_axis_tuser = fo.line_done;

  `LPS_ASSERT(a_start_silent, (in_acc && is_start) |-> !push0, "start item gave a point")
  `LPS_ASSERT(a_start_loads, (in_acc && is_start) |=> active_q, "start item did not load line")
  `LPS_ASSERT(a_pair_flags, push1 |-> (!f0.last_of_step && f1.last_of_step), "pair flags wrong")
  `LPS_ASSERT(a_done_clears, (push0 && st_done) |=> !active_q, "line still active after done")

endmodule

### hdl/lps_setup.sv
// Endpoint setup: axis swap, ordering along the major axis, spans.
// Depends on lps_pkg.
module lps_setup import lps_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output logic                         swapped_o,
  output logic signed [COORD_BITS-1:0] major_start_o,
  output logic signed [COORD_BITS-1:0] major_end_o,
  output logic signed [COORD_BITS-1:0] minor_start_o,
  output logic signed [COORD_BITS-1:0] minor_end_o,
  output logic        [COORD_BITS:0]   major_span_o,
  output logic        [COORD_BITS:0]   minor_span_o,
  output logic                         dir_down_o
);

  logic signed [COORD_BITS:0]   dx, dy, dmin;
  logic        [COORD_BITS:0]   adx, ady;
  logic signed [COORD_BITS-1:0] a1, a2, b1, b2;
  logic                         flip;

  always_comb begin
    dx  = $signed({x_end_i[COORD_BITS-1], x_end_i})
          - $signed({x_start_i[COORD_BITS-1], x_start_i});
    dy  = $signed({y_end_i[COORD_BITS-1], y_end_i})
          - $signed({y_start_i[COORD_BITS-1], y_start_i});
    adx = dx[COORD_BITS] ? -dx : dx;
    ady = dy[COORD_BITS] ? -dy : dy;
    swapped_o = ady > adx;

    if (swapped_o) begin
      a1 = y_start_i; b1 = x_start_i; a2 = y_end_i; b2 = x_end_i;
    end else begin
      a1 = x_start_i; b1 = y_start_i; a2 = x_end_i; b2 = y_end_i;
    end
    flip = a1 > a2;

    major_start_o = flip ? a2 : a1;
    major_end_o   = flip ? a1 : a2;
    minor_start_o = flip ? b2 : b1;
    minor_end_o   = flip ? b1 : b2;

    major_span_o = $signed({major_end_o[COORD_BITS-1], major_end_o})
                   - $signed({major_start_o[COORD_BITS-1], major_start_o});
    dmin = $signed({minor_end_o[COORD_BITS-1], minor_end_o})
           - $signed({minor_start_o[COORD_BITS-1], minor_start_o});
    minor_span_o = dmin[COORD_BITS] ? -dmin : dmin;
    dir_down_o   = minor_start_o < minor_end_o;
  end

endmodule

### hdl/lps_step.sv
// One column step: error update, minor step, result points in original axes.
// Depends on lps_pkg.
module lps_step import lps_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] major_pos_i,
  input  logic signed [COORD_BITS-1:0] major_end_i,
  input  logic signed [COORD_BITS:0]   minor_pos_i,
  input  logic signed [COORD_BITS-1:0] minor_end_i,
  input  logic signed [COORD_BITS+2:0] error_i,
  input  logic        [COORD_BITS:0]   major_span_i,
  input  logic        [COORD_BITS:0]   minor_span_i,
  input  logic                         dir_down_i,
  input  logic                         swapped_i,
  input  logic                         connected_i,
  output logic signed [COORD_BITS-1:0] major_pos_o,
  output logic signed [COORD_BITS:0]   minor_pos_o,
  output logic signed [COORD_BITS+2:0] error_o,
  output logic                         done_o,
  output logic                         extra_o,
  output logic signed [COORD_BITS-1:0] p0_x_o,
  output logic signed [COORD_BITS-1:0] p0_y_o,
  output logic signed [COORD_BITS-1:0] p1_x_o,
  output logic signed [COORD_BITS-1:0] p1_y_o
);

  logic signed [COORD_BITS+2:0] err_add, maj_span_ext;
  logic signed [COORD_BITS:0]   min_end_ext, min_step;
  logic                         hit, in_range;
  logic signed [COORD_BITS-1:0] min0, min1;

  always_comb begin
    done_o       = major_pos_i >= major_end_i;
    maj_span_ext = $signed({2'b00, major_span_i});
    err_add      = error_i + $signed({1'b0, minor_span_i, 1'b0});
    hit          = (major_span_i != '0) && (err_add >= maj_span_ext);
    error_o      = hit ? err_add - $signed({1'b0, major_span_i, 1'b0}) : err_add;

    min_step    = dir_down_i ? minor_pos_i + (COORD_BITS+1)'(1)
                             : minor_pos_i - (COORD_BITS+1)'(1);
    minor_pos_o = hit ? min_step : minor_pos_i;
    min_end_ext = $signed({minor_end_i[COORD_BITS-1], minor_end_i});
    in_range    = dir_down_i ? (min_step <= min_end_ext) : (min_step >= min_end_ext);
    extra_o     = connected_i && hit && in_range;

    major_pos_o = done_o ? major_pos_i : major_pos_i + COORD_BITS'(1);

    min0   = minor_pos_i[COORD_BITS-1:0];
    min1   = min_step[COORD_BITS-1:0];
    p0_x_o = swapped_i ? min0 : major_pos_i;
    p0_y_o = swapped_i ? major_pos_i : min0;
    p1_x_o = swapped_i ? min1 : major_pos_i;
    p1_y_o = swapped_i ? major_pos_i : min1;
  end

endmodule

### hdl/lps_result_fifo.sv
// Small result queue: takes up to two points per cycle, gives one per cycle while popped.
// Depends on lps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lps_result_fifo import lps_pkg::*; #(
  parameter int unsigned WIDTH = 2 * COORD_BITS_DEF + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push0_i,
  input  logic             push1_i,
  input  logic [WIDTH-1:0] data0_i,
  input  logic [WIDTH-1:0] data1_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] wr_ptr_nx;
  logic             pop;

  assign pop       = pop_i && valid_o;
  assign valid_o   = count_q != '0;
  assign room_o    = count_q <= CNT_W'(RES_DEPTH - 2);
  assign data_o    = mem_q[rd_ptr_q];
  assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push0_i) + PTR_W'(push1_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(push0_i) + CNT_W'(push1_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_nx] <= data1_i;
    end
  end

  `LPS_ASSERT(a_fifo_bound, count_q <= CNT_W'(RES_DEPTH), "result queue overfilled")
  `LPS_ASSERT(a_push_room, (push0_i || push1_i) |-> count_q <= CNT_W'(RES_DEPTH - 2), "push without room")
  `LPS_ASSERT(a_push_order, push1_i |-> push0_i, "second point pushed alone")
  `LPS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> count_q == '0, "queue not empty in reset")

endmodule

### sim/line_point_stepper_core_test.sv
`timescale 1ns / 1ps
// Testbench for line_point_stepper_core: start and step items go in, predicted
// line points are checked in order against the point stream.
// Depends on lps_pkg and the line_point_stepper_core RTL.
module line_point_stepper_core_test;
  import lps_pkg::*;

  localparam int CB           = COORD_BITS_DEF;
  localparam int IN_W         = ((4 * CB + 7) / 8) * 8;
  localparam int OUT_W        = ((2 * CB + 7) / 8) * 8;
  localparam int COORD_MAX    = (1 << (CB - 1)) - 1;
  localparam int COORD_MIN    = -(1 << (CB - 1));
  localparam int DRAIN_CYCLES = 4;   // margin for silent steps to settle
  localparam int REPORT_MAX   = 10;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    coord_t px;
    coord_t py;
    logic   last_flag;
    logic   done_flag;
  } line_point_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;  // x_start, y_start, x_end, y_end
  logic                  s_axis_tuser  = 1'b0; // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;        // point_x, point_y
  logic                  m_axis_tlast;        // last_of_step
  logic                  m_axis_tuser;        // line_done
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  line_point_stepper_core #(
    .COORD_BITS(CB)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL line_point_stepper_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line state mirror. Kept in int so the minor overshoot on the final column
  // does not wrap.
  // ---------------------------------------------------------------------------
  logic connected_q = 1'b0;
  logic line_live   = 1'b0;
  logic axes_swap   = 1'b0;
  logic minor_up    = 1'b0;
  int   maj_pos     = 0;
  int   min_pos     = 0;
  int   maj_end     = 0;
  int   min_end     = 0;
  int   maj_span    = 0;
  int   min_span    = 0;
  int   err_acc     = 0;

  line_point_t pending_points[$];
  int          mismatch_count = 0;
  int          burst_left     = 0;
  int          hold_request   = 0;

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("mismatch: %s", msg);
  endfunction

  // map major/minor back to x/y and queue the point
  function automatic void push_point(int maj, int mnr, logic last_flag, logic done_flag);
    line_point_t p;
    p.px        = axes_swap ? coord_t'(mnr) : coord_t'(maj);
    p.py        = axes_swap ? coord_t'(maj) : coord_t'(mnr);
    p.last_flag = last_flag;
    p.done_flag = done_flag;
    pending_points.push_back(p);
  endfunction

  // Bresenham with the error scaled by 2*dx: minor steps once err >= dx
  function automatic void rasterize_item(kind_e kind, coord_t xs, coord_t ys,
                                         coord_t xe, coord_t ye);
    int adx, ady, a1, b1, a2, b2;
    logic done_flag, extra;
    int col, first_minor;
    if (kind == KIND_START) begin
      adx = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
      ady = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
      axes_swap = ady > adx;
      if (axes_swap) begin
        a1 = ys; b1 = xs; a2 = ye; b2 = xe;
      end else begin
        a1 = xs; b1 = ys; a2 = xe; b2 = ye;
      end
      if (a1 > a2) begin
        {a1, a2} = {a2, a1};
        {b1, b2} = {b2, b1};
      end
      maj_pos   = a1;
      maj_end   = a2;
      min_pos   = b1;
      min_end   = b2;
      maj_span  = a2 - a1;
      min_span  = (b2 > b1) ? b2 - b1 : b1 - b2;
      minor_up  = b1 < b2;
      err_acc   = 0;
      line_live = 1'b1;
    end else if (line_live) begin
      done_flag   = maj_pos >= maj_end;
      col         = maj_pos;
      first_minor = min_pos;
      extra       = 1'b0;
      err_acc     = err_acc + 2 * min_span;
      if (maj_span > 0 && err_acc >= maj_span) begin
        min_pos = minor_up ? min_pos + 1 : min_pos - 1;
        err_acc = err_acc - 2 * maj_span;
        // no extra point once the stepped minor has run past its end
        extra   = connected_q && (minor_up ? (min_pos <= min_end) : (min_pos >= min_end));
      end
      push_point(col, first_minor, !extra, done_flag);
      if (extra) push_point(col, min_pos, 1'b1, done_flag);
      if (done_flag) line_live = 1'b0;
      else maj_pos = maj_pos + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Point side: check each accepted point, then pick tready for next cycle.
  // Stall pattern is redrawn at random among four modes; a hold request forces a long stall.
  // ---------------------------------------------------------------------------
  int rx_cycle  = 0;
  int rx_mode   = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    line_point_t want;
    coord_t      got_x, got_y;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_x = m_axis_tdata[CB-1:0];
        got_y = m_axis_tdata[2*CB-1:CB];
        if (pending_points.size() == 0) begin
          note_mismatch($sformatf("unexpected point x=%0d y=%0d last=%0b done=%0b",
                                  got_x, got_y, m_axis_tlast, m_axis_tuser));
        end else begin
          want = pending_points.pop_front();
          if (got_x !== want.px || got_y !== want.py ||
              m_axis_tlast !== want.last_flag || m_axis_tuser !== want.done_flag)
            note_mismatch($sformatf(
              "expected x=%0d y=%0d last=%0b done=%0b, got x=%0d y=%0d last=%0b done=%0b",
              want.px, want.py, want.last_flag, want.done_flag,
              got_x, got_y, m_axis_tlast, m_axis_tuser));
        end
      end
      rx_cycle++;
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (rx_cycle % 4 == 0);
          default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item side
  // ---------------------------------------------------------------------------
  // bursts of random length, random gaps between them
  task automatic send_item(kind_e kind, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {ye, xe, ys, xs};
    do @(posedge clk_i); while (!s_axis_tready);
    rasterize_item(kind, xs, ys, xe, ye);
    burst_left--;
  endtask

  // step items carry random, ignored coordinates
  task automatic send_step();
    send_item(KIND_STEP, coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic send_line(int xs, int ys, int xe, int ye, int steps);
    send_item(KIND_START, coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye));
    repeat (steps) send_step();
  endtask

  // idle the input, wait for every point, then let silent steps settle
  task automatic wait_points_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // setup and access phases, then an idle phase before the next transfer
  task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr,
                            logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_connected_mode(logic mode);
    logic [APB_DATA_W-1:0] rd;
    wait_points_drained();
    apb_access(1'b1, REG_CONNECTED_MODE, {{(APB_DATA_W-1){1'b0}}, mode}, rd);
    apb_access(1'b0, REG_CONNECTED_MODE, '0, rd);
    if (rd[0] !== mode)
      note_mismatch($sformatf("connected_mode readback expected %0b, got %0b", mode, rd[0]));
    connected_q = mode;
  endtask

  function automatic int offset_coord(int base, int d);
    int v;
    v = base + d;
    if (v > COORD_MAX || v < COORD_MIN) v = base - d;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // steps straight out of reset have no line and give nothing
  task automatic test_no_line_steps();
    send_step();
    send_step();
  endtask

  task automatic test_plain_lines();
    set_connected_mode(1'b0);
    send_line(5, -7, 5, -7, 2);                    // single point, then a step past the end
    send_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 2);  // full-range diagonal, cut short
    send_line(COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MAX, 1); // steep, replaces the above
    send_line(3, -1, 2, 2, 4);                     // steep, minor falling, replaces again
  endtask

  // minor steps give the extra point; the final one overshoots and does not
  task automatic test_connected_lines();
    set_connected_mode(1'b1);
    send_line(COORD_MIN, COORD_MIN, COORD_MIN + 3, COORD_MIN + 2, 4);
    send_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 2, 3);
  endtask

  // mostly whole short lines, some cut short or replaced, some stray steps
  task automatic test_random_lines(logic mode, int n_items);
    int sent, roll, dx, dy, span, ax, ay, steps;
    coord_t xs, ys, xe, ye;
    set_connected_mode(mode);
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_step();
        sent++;
      end else begin
        xs = coord_t'($urandom);
        ys = coord_t'($urandom);
        if (roll < 12) begin
          xe = coord_t'($urandom);
          ye = coord_t'($urandom);
        end else begin
          dx = $urandom_range(0, 16);
          case ($urandom_range(0, 3))
            0:       dy = 0;
            1:       dy = dx;
            default: dy = $urandom_range(0, 16);
          endcase
          if ($urandom_range(0, 1)) dx = -dx;
          if ($urandom_range(0, 1)) dy = -dy;
          xe = coord_t'(offset_coord(xs, dx));
          ye = coord_t'(offset_coord(ys, dy));
        end
        ax   = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
        ay   = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
        span = (ax > ay) ? ax : ay;
        if (roll < 12) steps = $urandom_range(0, 6);
        else if (roll < 22) steps = $urandom_range(0, span);
        else steps = span + 1 + $urandom_range(0, 1);
        send_item(KIND_START, xs, ys, xe, ye);
        sent++;
        repeat (steps) begin
          send_step();
          sent++;
        end
      end
    end
  endtask

  // long output stall while steps keep coming: two points per column fill the
  // result queue and the input must stall
  task automatic test_output_backpressure();
    set_connected_mode(1'b1);
    hold_request = 120;
    burst_left   = 1000;
    send_line(-20, -20, 20, 20, 41);
    send_line(7, 30, -2, -9, 40);
    burst_left   = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_line_steps();
    test_plain_lines();
    test_connected_lines();
    test_random_lines(1'b0, 270);
    test_random_lines(1'b1, 270);
    test_output_backpressure();
    wait_points_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("PASS line_point_stepper_core");
    end else begin
      $display("FAIL line_point_stepper_core");
    end
    $finish;
  end

endmodule
